// File: hdl/ogrm_pkg.sv
package ogrm_pkg;

  localparam int unsigned MapCellsDefault = 65536;
  localparam int unsigned MinStepDefault  = 10;

  localparam int CordicRounds = 15;
  localparam int CordicGain   = 19899;

  // width of a grid index before reduction to the map size
  localparam int IdxW = 18;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_MAP_READY   = 3'd0,
    REG_CELL_SIZE   = 3'd1,
    REG_ORIGIN_X    = 3'd2,
    REG_ORIGIN_Y    = 3'd3,
    REG_MAP_COLUMNS = 3'd4,
    REG_MAP_ROWS    = 3'd5,
    REG_OCC_LEVEL   = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_LIMX,
    S_LIMY,
    S_SETUP,
    S_MULX,
    S_POS,
    S_DIV,
    S_MULIDX,
    S_SUMIDX,
    S_REDUCE,
    S_ACCESS,
    S_CHECK,
    S_DONE
  } state_t;

  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/ogrm_if.sv
interface ogrm_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic        [15:0] cell_index;
  logic signed [7:0]  cell_value;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic        [15:0] heading;
  logic        [15:0] range_limit;
  modport source(output valid, opcode, cell_index, cell_value, pose_x, pose_y, heading,
                 range_limit, input ready);
  modport sink(input valid, opcode, cell_index, cell_value, pose_x, pose_y, heading,
               range_limit, output ready);
endinterface

interface ogrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic        hit;
  modport source(output valid, distance, hit, input ready);
  modport sink(input valid, distance, hit, output ready);
endinterface

interface ogrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/occupancy_grid_ray_march_core.sv
// channel  dir  handshake      payload
// req      in   valid/ready    opcode, cell_index, cell_value, pose_x, pose_y, heading,
//                              range_limit
// rsp      out  valid/ready    distance, hit
// cfg      in   valid/ready    index, data
//
// a write request is written to the map after index reduction when MAP_CELLS
// is not a power of two
// a cast runs direction setup (CORDIC rounds, map limits), then samples one at a time (two
// 9-step quotient loops on one compare/subtract unit, one shared multiplier, one map read),
// with index reduction per sample when MAP_CELLS is not a power of two
// reset is synchronous; registers return to their defaults and the grid stays unknown
// req is ready only in idle; a finished result waits in its own register while rsp stalls
module occupancy_grid_ray_march_core
  import ogrm_pkg::*;
#(
  parameter int unsigned MAP_CELLS = MapCellsDefault,
  parameter int unsigned MIN_STEP  = MinStepDefault
) (
  input  logic       clk,
  input  logic       rst,
  ogrm_req_if.sink   req,
  ogrm_rsp_if.source rsp,
  ogrm_cfg_if.sink   cfg
);

  localparam int  AW   = $clog2(MAP_CELLS);
  localparam bit  POW2 = (MAP_CELLS & (MAP_CELLS - 1)) == 0;

  state_t state, state_next;

  logic               map_ready;
  logic [15:0]        cell_size;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [8:0]         map_columns;
  logic [8:0]         map_rows;
  logic signed [7:0]  occupied_level;

  logic               op;
  logic [7:0]         wval;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic [15:0]        range_q;
  logic [IdxW-1:0]    idx;
  logic [4:0]         mk;

  logic signed [17:0] cx, cy;
  logic signed [16:0] cz;
  logic [3:0]         iter;
  logic signed [15:0] cdir, sdir;

  logic [15:0]        res;
  logic [15:0]        step;
  logic [24:0]        lim_x, lim_y;
  logic [16:0]        t;
  logic               axis;
  logic signed [35:0] prod;
  logic [24:0]        rem;
  logic [8:0]         quo;
  logic [3:0]         k;
  logic [8:0]         gx, gy;

  logic [15:0]        pend_dist;
  logic               pend_hit;
  logic               out_valid;
  logic [15:0]        out_dist;
  logic               out_hit;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_rdata;

  ogrm_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wval),
    .rdata(ram_rdata)
  );

  assign req.ready    = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign rsp.valid    = out_valid;
  assign rsp.distance = out_dist;
  assign rsp.hit      = out_hit;
  assign ram_we       = (state == S_ACCESS) && (op == OP_WRITE);
  assign ram_addr     = AW'(idx);

  logic req_fire;
  assign req_fire = req.valid && req.ready;

  // cordic rotation
  logic signed [17:0] xs, ys, cx_step, cy_step;
  logic signed [16:0] cz_step;
  logic signed [16:0] hz;
  always_comb begin
    xs = cx >>> iter;
    ys = cy >>> iter;
    if (cz >= 0) begin
      cx_step = cx - ys;
      cy_step = cy + xs;
      cz_step = cz - 17'($signed({1'b0, atan_step(iter)}));
    end else begin
      cx_step = cx + ys;
      cy_step = cy - xs;
      cz_step = cz + 17'($signed({1'b0, atan_step(iter)}));
    end
    hz = 17'($signed(req.heading));
  end

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return -16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  always_comb begin
    case (state)
      S_LIMX: begin
        mul_a = $signed({9'd0, map_columns});
        mul_b = $signed({2'd0, res});
      end
      S_LIMY: begin
        mul_a = $signed({9'd0, map_rows});
        mul_b = $signed({2'd0, res});
      end
      S_MULX: begin
        mul_a = $signed({1'b0, t});
        mul_b = axis ? 18'(sdir) : 18'(cdir);
      end
      default: begin
        mul_a = $signed({9'd0, gy});
        mul_b = $signed({9'd0, map_columns});
      end
    endcase
  end

  // sample position relative to the map corner
  logic signed [26:0] dpos;
  logic [24:0]        lim;
  always_comb begin
    dpos = (axis ? 27'(pose_y) : 27'(pose_x)) + 27'(prod >>> 15)
         - (axis ? 27'(origin_y) : 27'(origin_x));
    lim  = axis ? lim_x ^ lim_x ^ lim_y : lim_x;
  end

  // quotient step
  logic [24:0] trial;
  logic        qbit;
  logic [8:0]  quo_next;
  always_comb begin
    trial    = 25'(res) << k;
    qbit     = (rem >= trial);
    quo_next = {quo[7:0], qbit};
  end

  logic        reduce_take;
  logic [16:0] t_next;
  logic        is_hit;
  always_comb begin
    reduce_take = 64'(idx) >= (64'(MAP_CELLS) << mk);
    t_next      = t + 17'(step);
    is_hit      = $signed(ram_rdata) >= occupied_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.opcode == OP_WRITE) begin
            state_next = POW2 ? S_ACCESS : S_REDUCE;
          end else if (!map_ready) begin
            state_next = S_DONE;
          end else begin
            state_next = S_CORDIC;
          end
        end
      end
      S_CORDIC: if (iter == 4'(CordicRounds - 1)) state_next = S_LIMX;
      S_LIMX:   state_next = S_LIMY;
      S_LIMY:   state_next = S_SETUP;
      S_SETUP:  state_next = S_MULX;
      S_MULX:   state_next = S_POS;
      S_POS: begin
        if (dpos < 0 || dpos >= $signed({2'b0, lim})) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (k == 4'd0) state_next = axis ? S_MULIDX : S_MULX;
      end
      S_MULIDX: state_next = S_SUMIDX;
      S_SUMIDX: state_next = POW2 ? S_ACCESS : S_REDUCE;
      S_REDUCE: if (mk == 5'd0) state_next = S_ACCESS;
      S_ACCESS: state_next = (op == OP_WRITE) ? S_IDLE : S_CHECK;
      S_CHECK: begin
        if (is_hit || t_next > {1'b0, range_q}) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MULX;
        end
      end
      S_DONE:   if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          op        <= req.opcode;
          wval      <= req.cell_value;
          idx       <= IdxW'(req.cell_index);
          mk        <= 5'(IdxW - 1);
          pose_x    <= req.pose_x;
          pose_y    <= req.pose_y;
          range_q   <= req.range_limit;
          pend_dist <= req.range_limit;
          pend_hit  <= 1'b0;
          t         <= '0;
          axis      <= 1'b0;
          iter      <= '0;
          cy        <= '0;
          res       <= (cell_size == 16'd0) ? 16'd1 : cell_size;
          step      <= ((cell_size >> 1) < 16'(MIN_STEP)) ? 16'(MIN_STEP) : (cell_size >> 1);
          if (hz > 17'sd16384) begin
            cx <= -18'(CordicGain);
            cz <= hz - 17'sd32768;
          end else if (hz < -17'sd16384) begin
            cx <= -18'(CordicGain);
            cz <= hz + 17'sd32768;
          end else begin
            cx <= 18'(CordicGain);
            cz <= hz;
          end
        end
      end
      S_CORDIC: begin
        cx   <= cx_step;
        cy   <= cy_step;
        cz   <= cz_step;
        iter <= iter + 4'd1;
      end
      S_LIMX: begin
        cdir <= sat16(cx);
        sdir <= sat16(cy);
      end
      S_LIMY:  lim_x <= prod[24:0];
      S_SETUP: lim_y <= prod[24:0];
      S_POS: begin
        rem <= dpos[24:0];
        quo <= '0;
        k   <= 4'd8;
      end
      S_DIV: begin
        if (qbit) rem <= rem - trial;
        quo <= quo_next;
        k   <= k - 4'd1;
        if (k == 4'd0) begin
          if (axis) gy <= quo_next;
          else      gx <= quo_next;
          axis <= ~axis;
        end
      end
      S_SUMIDX: begin
        idx <= IdxW'(prod) + IdxW'(gx);
        mk  <= 5'(IdxW - 1);
      end
      S_REDUCE: begin
        if (reduce_take) idx <= IdxW'(64'(idx) - (64'(MAP_CELLS) << mk));
        mk <= mk - 5'd1;
      end
      S_CHECK: begin
        if (is_hit) begin
          pend_dist <= t[15:0];
          pend_hit  <= 1'b1;
        end
        t    <= t_next;
        axis <= 1'b0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_dist <= pend_dist;
      out_hit  <= pend_hit;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_ready      <= 1'b0;
      cell_size      <= 16'd51;
      origin_x       <= '0;
      origin_y       <= '0;
      map_columns    <= 9'd256;
      map_rows       <= 9'd256;
      occupied_level <= 8'sd65;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MAP_READY:   map_ready      <= cfg.data[0];
        REG_CELL_SIZE:   cell_size      <= cfg.data[15:0];
        REG_ORIGIN_X:    origin_x       <= cfg.data;
        REG_ORIGIN_Y:    origin_y       <= cfg.data;
        REG_MAP_COLUMNS: map_columns    <= cfg.data[8:0];
        REG_MAP_ROWS:    map_rows       <= cfg.data[8:0];
        REG_OCC_LEVEL:   occupied_level <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CORDIC |-> iter < 4'(CordicRounds))
    else $error("cordic round counter overran");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> 26'(rem) < (26'(res) << (k + 4'd1)))
    else $error("quotient loop remainder out of range");

  a_no_map: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == OP_CAST && !map_ready) |=> state == S_DONE)
    else $error("cast without a map did not finish at once");

endmodule

// File: hdl/ogrm_ram.sv
module ogrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import ogrm_pkg::*;

  typedef struct {
    opcode_t            op;
    logic        [15:0] idx;
    logic signed [7:0]  val;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic        [15:0] hd;
    logic        [15:0] rng;
  } grid_req_t;

  typedef struct {
    logic [15:0] reach;
    logic        hit;
  } ray_result_t;

  localparam int AtanTab[CordicRounds] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                           41, 20, 10, 5, 3, 1, 1};

  logic clk;
  logic rst;

  ogrm_req_if req_ch();
  ogrm_rsp_if rsp_ch();
  ogrm_cfg_if cfg_ch();

  occupancy_grid_ray_march_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // model copy of registers and grid
  logic               m_ready;
  logic        [15:0] m_cell;
  logic signed [23:0] m_ox;
  logic signed [23:0] m_oy;
  logic        [8:0]  m_cols;
  logic        [8:0]  m_rows;
  logic signed [7:0]  m_level;
  logic signed [7:0]  m_grid[MapCellsDefault];
  bit                 filled[MapCellsDefault];

  grid_req_t   pending[$];
  ray_result_t ranges_due[$];

  int mismatches = 0;
  int casts_done = 0;
  int hits_seen = 0;
  int writes_done = 0;
  int phases_run = 0;

  int burst_left = 0;
  int gap_left = 0;
  bit req_taken = 0;
  int rcv_cnt = 0;
  int rcv_mode = 0;
  int hold_cnt = 0;
  bit hold_go = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic void heading_to_dir(input logic [15:0] h, output int c, output int s);
    int z, x, y, xs, ys;
    z = int'($signed(h));
    x = CordicGain;
    y = 0;
    if (z > 16384) begin
      x = -x;
      z -= 32768;
    end else if (z < -16384) begin
      x = -x;
      z += 32768;
    end
    for (int i = 0; i < CordicRounds; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= AtanTab[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z += AtanTab[i];
      end
    end
    c = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
    s = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
  endfunction

  function automatic ray_result_t trace_ray(grid_req_t it);
    ray_result_t r;
    longint res, px, py, gx, gy, stp, t, idx;
    int c, s;
    r.reach = it.rng;
    r.hit = 1'b0;
    if (!m_ready) return r;
    res = (m_cell == 0) ? 1 : longint'(m_cell);
    stp = res >> 1;
    if (stp < MinStepDefault) stp = MinStepDefault;
    heading_to_dir(it.hd, c, s);
    for (t = 0; t <= longint'(it.rng); t += stp) begin
      px = longint'(it.px) + ((t * c) >>> 15);
      py = longint'(it.py) + ((t * s) >>> 15);
      gx = floor_div(px - longint'(m_ox), res);
      gy = floor_div(py - longint'(m_oy), res);
      if (gx < 0 || gy < 0 || gx >= longint'(m_cols) || gy >= longint'(m_rows)) return r;
      idx = (gy * longint'(m_cols) + gx) % MapCellsDefault;
      if (m_grid[idx] >= m_level) begin
        r.reach = t[15:0];
        r.hit = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      if (pending[0].op == OP_WRITE) begin
        m_grid[pending[0].idx] = pending[0].val;
        writes_done++;
      end else begin
        ranges_due.push_back(trace_ray(pending[0]));
      end
      void'(pending.pop_front());
      req_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && !req_taken)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0 && burst_left == 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        if (burst_left > 0) burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.opcode <= pending[0].op;
        req_ch.cell_index <= pending[0].idx;
        req_ch.cell_value <= pending[0].val;
        req_ch.pose_x <= pending[0].px;
        req_ch.pose_y <= pending[0].py;
        req_ch.heading <= pending[0].hd;
        req_ch.range_limit <= pending[0].rng;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    req_taken = 0;
  end

  // response receiver
  always @(negedge clk) begin
    rcv_cnt++;
    if (rcv_cnt % 64 == 0) rcv_mode = $urandom_range(0, 2);
    if (hold_go && hold_cnt == 0) begin
      hold_cnt = 400;
      hold_go = 0;
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rcv_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= (rcv_cnt % 3) != 0;
        default: rsp_ch.ready <= (rcv_cnt % 8) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (ranges_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d hit %0d", rsp_ch.distance, rsp_ch.hit);
      end else begin
        if (rsp_ch.distance !== ranges_due[0].reach || rsp_ch.hit !== ranges_due[0].hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cast %0d: expected distance %0d hit %0d, got distance %0d hit %0d",
                     casts_done, ranges_due[0].reach, ranges_due[0].hit,
                     rsp_ch.distance, rsp_ch.hit);
        end
        if (ranges_due[0].hit) hits_seen++;
        void'(ranges_due.pop_front());
        casts_done++;
      end
    end
  end

  task automatic write_reg(reg_index_t ri, logic [23:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ri;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (ri)
      REG_MAP_READY:   m_ready = data[0];
      REG_CELL_SIZE:   m_cell = data[15:0];
      REG_ORIGIN_X:    m_ox = data;
      REG_ORIGIN_Y:    m_oy = data;
      REG_MAP_COLUMNS: m_cols = data[8:0];
      REG_MAP_ROWS:    m_rows = data[8:0];
      default:         m_level = data[7:0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || ranges_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void add_write(int idx, int val);
    grid_req_t it;
    it = '{OP_WRITE, idx[15:0], val[7:0], 24'd0, 24'd0, 16'd0, 16'd0};
    pending.push_back(it);
  endfunction

  function automatic void add_cast(logic [23:0] px, logic [23:0] py, int hd, int rng);
    grid_req_t it;
    it = '{OP_CAST, 16'd0, 8'sd0, px, py, hd[15:0], rng[15:0]};
    pending.push_back(it);
  endfunction

  function automatic void add_phase_items(int n);
    int area, cs, stp, span;
    longint px, py;
    area = m_cols * m_rows;
    cs = (m_cell == 0) ? 1 : m_cell;
    stp = cs / 2;
    if (stp < MinStepDefault) stp = MinStepDefault;
    for (int i = 0; i < area; i++) begin
      if (!filled[i]) begin
        filled[i] = 1;
        add_write(i, $urandom_range(0, 255));
      end
    end
    // rays from the map corner: zero range, a half turn and a quarter turn
    add_cast(m_ox, m_oy, 0, 0);
    add_cast(m_ox, m_oy, 32768, stp * 3);
    add_cast(m_ox, m_oy, 16384, stp * 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: add_write($urandom_range(0, area - 1), $urandom_range(0, 255));
        2: add_write($urandom_range(0, 65535), $urandom_range(0, 255));
        3: add_cast(24'($urandom), 24'($urandom), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
        default: begin
          span = m_cols * cs;
          px = longint'(m_ox) + $urandom_range(0, span - 1);
          span = m_rows * cs;
          py = longint'(m_oy) + $urandom_range(0, span - 1);
          span = stp * 16;
          if (span > 65535) span = 65535;
          add_cast(px[23:0], py[23:0], $urandom_range(0, 65535), $urandom_range(0, span));
        end
      endcase
    end
  endfunction

  initial begin
    int cs_opts[6];
    int cols, rows;
    cs_opts = '{1, 2, 51, 1024, 65535, 300};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_WRITE;
    req_ch.cell_index = '0;
    req_ch.cell_value = '0;
    req_ch.pose_x = '0;
    req_ch.pose_y = '0;
    req_ch.heading = '0;
    req_ch.range_limit = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAP_READY;
    cfg_ch.data = '0;
    m_ready = 1'b0;
    m_cell = 16'd51;
    m_ox = '0;
    m_oy = '0;
    m_cols = 9'd256;
    m_rows = 9'd256;
    m_level = 8'sd65;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no map loaded: casts miss without touching the grid
    add_write(0, 8'h80);
    add_write(65535, 8'h7f);
    add_cast(24'h800000, 24'h7fffff, 0, 65535);
    add_cast(24'h7fffff, 24'h800000, 65535, 0);
    add_cast(24'h000000, 24'h000000, 16384, 1234);
    add_cast(24'hffffff, 24'h555555, 49151, 40000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin cols = 16; rows = 16; end
        1: begin cols = 256; rows = 1; end
        2: begin cols = 1; rows = 256; end
        default: begin
          cols = $urandom_range(1, 20);
          rows = $urandom_range(1, 256 / cols);
        end
      endcase
      if (ph == 5) begin cols = 1; rows = 1; end
      write_reg(REG_MAP_READY, (ph == 7) ? 24'd0 : 24'd1);
      write_reg(REG_CELL_SIZE, 24'(cs_opts[ph % 6]));
      write_reg(REG_ORIGIN_X, (ph == 4) ? 24'h800000 : (ph == 9) ? 24'h7fffff : 24'($urandom));
      write_reg(REG_ORIGIN_Y, (ph == 4) ? 24'h7fffff : (ph == 9) ? 24'h800000 : 24'($urandom));
      write_reg(REG_MAP_COLUMNS, 24'(cols));
      write_reg(REG_MAP_ROWS, 24'(rows));
      write_reg(REG_OCC_LEVEL,
                (ph == 2) ? 24'h80 : (ph == 3) ? 24'h7f : 24'($urandom_range(0, 255)));
      if (ph == 3) hold_go = 1;
      add_phase_items(67);
      drain();
      phases_run++;
    end

    repeat (100) @(posedge clk);
    $display("ran %0d register settings: %0d cell writes, %0d casts checked, %0d hits",
             phases_run, writes_done, casts_done, hits_seen);
    if (mismatches == 0 && ranges_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
